/* rtl/core/drpcw_pkg.sv */
// ----------------------------------------------------------------------------
// Dual RGB PWM color wheel package
// Shared widths, register indexes, reset values, level types and the
// color wheel step function.
// ----------------------------------------------------------------------------
package drpcw_pkg;

   localparam int PHASE_W   = 9;
   localparam int LEVEL_W   = 8;
   localparam int RGB_W     = 3 * LEVEL_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = RGB_W;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_WINDOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_EN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_THRESH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_START   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_START  = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [PHASE_W-1:0] RST_PWM_PERIOD  = 9'd256;
   localparam logic [PHASE_W-1:0] RST_ON_WINDOW   = 9'd8;
   localparam logic [LEVEL_W-1:0] RST_COLOR_STEP  = 8'd1;
   localparam logic [LEVEL_W-1:0] RST_ROT_THRESH  = 8'd4;
   localparam logic [RGB_W-1:0]   RST_LEFT_START  = 24'h800020;
   localparam logic [RGB_W-1:0]   RST_RIGHT_START = 24'h008080;

   // Bit positions inside the LED pattern.
   localparam int PAT_RIGHT_R = 0;
   localparam int PAT_RIGHT_G = 1;
   localparam int PAT_RIGHT_B = 2;
   localparam int PAT_LEFT_R  = 3;
   localparam int PAT_LEFT_G  = 4;
   localparam int PAT_LEFT_B  = 5;
   localparam int PAT_W       = 6;

   // Packed so that a 24-bit start value maps to R[23:16] G[15:8] B[7:0].
   typedef struct packed {
      logic [LEVEL_W-1:0] r;
      logic [LEVEL_W-1:0] g;
      logic [LEVEL_W-1:0] b;
   } rgb_type;

   function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                  input logic [LEVEL_W-1:0] b);
      logic [LEVEL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[LEVEL_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] sat_sub(input logic [LEVEL_W-1:0] a,
                                                  input logic [LEVEL_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   // One step along the six-segment wheel; the first matching rule wins.
   function automatic rgb_type wheel_step(input rgb_type cur,
                                          input logic [LEVEL_W-1:0] thr,
                                          input logic [LEVEL_W-1:0] stp);
      rgb_type nxt;
      nxt = cur;
      priority if (cur.r >= thr && cur.g < thr && cur.b == '0) begin
         nxt.g = sat_add(cur.g, stp);
      end else if (cur.g >= thr && cur.r != '0 && cur.b == '0) begin
         nxt.r = sat_sub(cur.r, stp);
      end else if (cur.g >= thr && cur.b < thr) begin
         nxt.b = sat_add(cur.b, stp);
      end else if (cur.b >= thr && cur.g != '0) begin
         nxt.g = sat_sub(cur.g, stp);
      end else if (cur.b >= thr && cur.r < thr) begin
         nxt.r = sat_add(cur.r, stp);
      end else if (cur.r >= thr && cur.b != '0) begin
         nxt.b = sat_sub(cur.b, stp);
      end else begin
         nxt = cur;
      end
      return nxt;
   endfunction

endpackage

/* rtl/core/dual_rgb_pwm_color_wheel_core.sv */
// ----------------------------------------------------------------------------
// Dual RGB PWM color wheel core
// Software-style PWM for two RGB LEDs with an optional color wheel rotation.
// ----------------------------------------------------------------------------
// The req channel carries one timer tick per transfer (req_tdata[0]). Every
// accepted transfer produces exactly one transfer on the rsp channel, holding
// the six LED bits for the phase after the update and a flag that is set when
// that tick wrapped the phase counter back to zero.
// An accepted transfer is registered in the result register and shown on rsp
// in the next cycle. Throughput is one transfer per cycle while rsp is not
// stalled; the phase and level update is a single pass of compares and one
// saturating add or subtract per LED between the state and result registers.
// The result register frees itself in the same cycle that rsp is taken, so
// req_tready follows rsp_tready while a result is pending. When the receiver
// stalls, the pending result holds and req is back-pressured; no tick is lost.
// The csr port writes seven registers by index; a write of either start
// register loads that LED's live levels directly. Writes are meant to
// happen while the channels are idle.
// Synchronous reset clears the phase, empties the result register and loads
// the register reset values, including the start levels of both LEDs.
// ----------------------------------------------------------------------------
module dual_rgb_pwm_color_wheel_core
   import drpcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Request stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] tick, [7:1] zero
   // Response stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [5:0] led_pattern, [6] phase_wrapped, [7] zero
   // Configuration write port.
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CSR_DAT_W-1:0] csr_wr_data
);

   // Configuration registers.
   logic [PHASE_W-1:0] period_ff,    period_in;
   logic [PHASE_W-1:0] window_ff,    window_in;
   logic               rotate_ff,    rotate_in;
   logic [LEVEL_W-1:0] step_ff,      step_in;
   logic [LEVEL_W-1:0] thresh_ff,    thresh_in;

   // Live state.
   logic [PHASE_W-1:0] phase_ff,     phase_in;
   rgb_type            left_ff,      left_in;
   rgb_type            right_ff,     right_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PAT_W-1:0]   rsp_pat_ff,   rsp_pat_in;
   logic               rsp_wrap_ff,  rsp_wrap_in;

   logic               req_accept;
   logic               tick;
   logic [PHASE_W-1:0] phase_next;
   logic               wrapped;
   logic               lit_window;
   logic [PAT_W-1:0]   pattern;
   logic               do_step;

   // The result register can take a new item when empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign tick       = req_tdata[0];

   // Phase counter advances on a tick and wraps once it reaches the period.
   always_comb begin
      if (tick) begin
         phase_next = (phase_ff < period_ff) ? PHASE_W'(phase_ff + 1'b1) : '0;
      end else begin
         phase_next = phase_ff;
      end
   end

   assign wrapped    = tick && (phase_next == '0);
   assign lit_window = phase_next < window_ff;

   // Each LED bit is lit while the phase is in the on window and below that channel's level.
   always_comb begin
      pattern = '0;
      if (lit_window) begin
         pattern[PAT_LEFT_R]  = phase_next < {1'b0, left_ff.r};
         pattern[PAT_LEFT_G]  = phase_next < {1'b0, left_ff.g};
         pattern[PAT_LEFT_B]  = phase_next < {1'b0, left_ff.b};
         pattern[PAT_RIGHT_R] = phase_next < {1'b0, right_ff.r};
         pattern[PAT_RIGHT_G] = phase_next < {1'b0, right_ff.g};
         pattern[PAT_RIGHT_B] = phase_next < {1'b0, right_ff.b};
      end
   end

   // The wheel steps after the pattern is formed from the old levels.
   assign do_step = req_accept && wrapped && rotate_ff;

   always_comb begin
      period_in = period_ff;
      window_in = window_ff;
      rotate_in = rotate_ff;
      step_in   = step_ff;
      thresh_in = thresh_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      phase_in  = req_accept ? phase_next : phase_ff;

      if (do_step) begin
         left_in  = wheel_step(left_ff,  thresh_ff, step_ff);
         right_in = wheel_step(right_ff, thresh_ff, step_ff);
      end

      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_PWM_PERIOD:  period_in = csr_wr_data[PHASE_W-1:0];
            CSR_ON_WINDOW:   window_in = csr_wr_data[PHASE_W-1:0];
            CSR_ROTATE_EN:   rotate_in = csr_wr_data[0];
            CSR_COLOR_STEP:  step_in   = csr_wr_data[LEVEL_W-1:0];
            CSR_ROT_THRESH:  thresh_in = csr_wr_data[LEVEL_W-1:0];
            CSR_LEFT_START:  left_in   = csr_wr_data[RGB_W-1:0];
            CSR_RIGHT_START: right_in  = csr_wr_data[RGB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pat_in   = rsp_pat_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_pat_in   = pattern;
         rsp_wrap_in  = wrapped;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= RST_PWM_PERIOD;
         window_ff    <= RST_ON_WINDOW;
         rotate_ff    <= 1'b0;
         step_ff      <= RST_COLOR_STEP;
         thresh_ff    <= RST_ROT_THRESH;
         phase_ff     <= '0;
         left_ff      <= RST_LEFT_START;
         right_ff     <= RST_RIGHT_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         window_ff    <= window_in;
         rotate_ff    <= rotate_in;
         step_ff      <= step_in;
         thresh_ff    <= thresh_in;
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the result register needs no reset.
   always_ff @(posedge clock) begin
      rsp_pat_ff  <= rsp_pat_in;
      rsp_wrap_ff <= rsp_wrap_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_wrap_ff, rsp_pat_ff};

`ifndef ASSERT_OFF
   // A tick taken at or above the period must leave the phase at zero.
   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      req_accept && tick && (phase_ff >= period_ff) |=> phase_ff == '0)
      else $error("phase counter did not wrap");

   // The phase only moves on an accepted transfer.
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(phase_ff))
      else $error("phase moved without a transfer");

   // A pending wrap flag belongs to the phase that is held now.
   a_wrap_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wrap_ff |-> phase_ff == '0)
      else $error("wrap flag shown with a nonzero phase");

   // Levels change only through a wheel step or a start register write.
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      !do_step && !(csr_wr_en && (csr_addr == CSR_LEFT_START ||
                                  csr_addr == CSR_RIGHT_START))
      |=> $stable(left_ff) && $stable(right_ff))
      else $error("levels changed without a step or write");
`endif

endmodule

/* test/pwm_wheel_checker.sv */
// ----------------------------------------------------------------------------
// PWM color wheel checker
// Watches the tick, result and register channels of the dual RGB PWM core.
// It keeps its own copy of the phase, the six levels and the registers,
// predicts the LED pattern and wrap flag of every tick transfer, and compares
// each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module pwm_wheel_checker
   import drpcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] tick, [7:1] zero
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [7:0]           rsp_tdata,   // [5:0] led_pattern, [6] phase_wrapped, [7] zero
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CSR_DAT_W-1:0] csr_wr_data,
   output int                   fail_count,
   output int                   pending,
   output int                   wrap_count,
   output int                   step_count
);

   typedef struct packed {
      logic [PAT_W-1:0] pattern;
      logic             wrapped;
   } led_result_t;

   logic [PHASE_W-1:0] period_q;
   logic [PHASE_W-1:0] window_q;
   logic               rotate_q;
   logic [LEVEL_W-1:0] step_q;
   logic [LEVEL_W-1:0] thresh_q;
   logic [PHASE_W-1:0] phase_q;
   rgb_type            left_q;
   rgb_type            right_q;

   led_result_t expected_leds[$];
   int errs;
   int wraps;
   int steps;

   function automatic logic [LEVEL_W-1:0] clip_up(input logic [LEVEL_W-1:0] lvl,
                                                  input logic [LEVEL_W-1:0] amt);
      return (lvl > 8'hFF - amt) ? 8'hFF : lvl + amt;
   endfunction

   function automatic logic [LEVEL_W-1:0] clip_down(input logic [LEVEL_W-1:0] lvl,
                                                    input logic [LEVEL_W-1:0] amt);
      return (amt >= lvl) ? 8'h00 : lvl - amt;
   endfunction

   // One move along the six-segment wheel; the first rule that holds wins.
   function automatic rgb_type wheel_advance(input rgb_type c);
      rgb_type n;
      n = c;
      if (c.r >= thresh_q && c.g < thresh_q && c.b == 8'h00)
         n.g = clip_up(c.g, step_q);
      else if (c.g >= thresh_q && c.r > 8'h00 && c.b == 8'h00)
         n.r = clip_down(c.r, step_q);
      else if (c.g >= thresh_q && c.b < thresh_q)
         n.b = clip_up(c.b, step_q);
      else if (c.b >= thresh_q && c.g > 8'h00)
         n.g = clip_down(c.g, step_q);
      else if (c.b >= thresh_q && c.r < thresh_q)
         n.r = clip_up(c.r, step_q);
      else if (c.r >= thresh_q && c.b > 8'h00)
         n.b = clip_down(c.b, step_q);
      return n;
   endfunction

   always @(posedge clock) begin : monitor
      led_result_t      want;
      logic [PAT_W-1:0] pat;
      if (reset) begin
         period_q = RST_PWM_PERIOD;
         window_q = RST_ON_WINDOW;
         rotate_q = 1'b0;
         step_q   = RST_COLOR_STEP;
         thresh_q = RST_ROT_THRESH;
         phase_q  = '0;
         left_q   = RST_LEFT_START;
         right_q  = RST_RIGHT_START;
         expected_leds.delete();
         errs  = 0;
         wraps = 0;
         steps = 0;
      end else begin
         // A result taken at this edge always belongs to an earlier tick.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_leds.size() == 0) begin
               $error("result transfer with no prediction waiting: tdata %02h", rsp_tdata);
               errs++;
            end else begin
               want = expected_leds.pop_front();
               if (rsp_tdata[PAT_W-1:0] !== want.pattern) begin
                  $error("led_pattern: expected %02h, actual %02h",
                         want.pattern, rsp_tdata[PAT_W-1:0]);
                  errs++;
               end
               if (rsp_tdata[PAT_W] !== want.wrapped) begin
                  $error("phase_wrapped: expected %0b, actual %0b",
                         want.wrapped, rsp_tdata[PAT_W]);
                  errs++;
               end
            end
         end

         if (csr_wr_en) begin
            case (csr_addr)
               CSR_PWM_PERIOD:  period_q = csr_wr_data[PHASE_W-1:0];
               CSR_ON_WINDOW:   window_q = csr_wr_data[PHASE_W-1:0];
               CSR_ROTATE_EN:   rotate_q = csr_wr_data[0];
               CSR_COLOR_STEP:  step_q   = csr_wr_data[LEVEL_W-1:0];
               CSR_ROT_THRESH:  thresh_q = csr_wr_data[LEVEL_W-1:0];
               CSR_LEFT_START:  left_q   = csr_wr_data;
               CSR_RIGHT_START: right_q  = csr_wr_data;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            want.wrapped = 1'b0;
            if (req_tdata[0]) begin
               phase_q = (phase_q < period_q) ? phase_q + 1'b1 : '0;
               want.wrapped = (phase_q == '0);
            end
            pat = '0;
            if (phase_q < window_q) begin
               pat[PAT_LEFT_R]  = phase_q < left_q.r;
               pat[PAT_LEFT_G]  = phase_q < left_q.g;
               pat[PAT_LEFT_B]  = phase_q < left_q.b;
               pat[PAT_RIGHT_R] = phase_q < right_q.r;
               pat[PAT_RIGHT_G] = phase_q < right_q.g;
               pat[PAT_RIGHT_B] = phase_q < right_q.b;
            end
            want.pattern = pat;
            // The pattern of a wrapping tick still uses the levels before the step.
            if (want.wrapped) begin
               wraps++;
               if (rotate_q) begin
                  left_q  = wheel_advance(left_q);
                  right_q = wheel_advance(right_q);
                  steps++;
               end
            end
            expected_leds.push_back(want);
         end
      end
      fail_count <= errs;
      pending    <= expected_leds.size();
      wrap_count <= wraps;
      step_count <= steps;
   end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Dual RGB PWM color wheel core testbench
// Drives timer ticks into the core under random source gaps and receiver
// stalls, reprograms registers between runs of ticks, and lets a checker
// module predict and compare every LED pattern transfer.
// ----------------------------------------------------------------------------
module tb;
   import drpcw_pkg::*;

   // Index past the end of the register list; a write there must do nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // Number of random tick transfers to send after the directed part.
   localparam int RANDOM_TICKS = 1950;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata   = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr    = '0;
   logic [CSR_DAT_W-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;
   int wrap_count;
   int step_count;

   // When set, neither side idles: a stretch at full rate.
   bit quiet      = 1'b0;
   int sink_hold  = 0;
   int ticks_sent = 0;
   int settings   = 0;

   always #10 clock = ~clock;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   dual_rgb_pwm_color_wheel_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   pwm_wheel_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .wrap_count  (wrap_count),
      .step_count  (step_count)
   );

   // Idle lengths: mostly none, often a few cycles, now and then a long one.
   function automatic int gap_len();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A level, step or threshold: the extremes now and then, small values mostly,
   // since small values are what the short PWM periods of the test can show.
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return LEVEL_W'($urandom_range(0, 255));
         default: return LEVEL_W'($urandom_range(0, 20));
      endcase
   endfunction

   // Narrow registers sometimes get junk above their width, which the core
   // has to ignore.
   function automatic logic [CSR_DAT_W-1:0] with_noise(input logic [CSR_DAT_W-1:0] value,
                                                       input int width);
      logic [CSR_DAT_W-1:0] noise;
      noise = CSR_DAT_W'($urandom());
      if ($urandom_range(0, 3) != 0) return value;
      return value | (noise << width);
   endfunction

   // The receiver: each cycle outside a stall either takes results or starts one.
   always @(posedge clock) begin : sink
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold  <= 0;
      end else if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else begin
         gap = gap_len();
         if (gap == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            sink_hold  <= gap - 1;
         end
      end
   end

   // One register write; the enable is high for exactly one edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Offers one tick transfer after a random gap and returns at the edge that
   // accepts it. The valid stays high so that back-to-back transfers need no
   // second assignment in the same step.
   task automatic push_tick(input logic [7:0] data);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Stops offering ticks and waits until every predicted result has been
   // taken. Every tick gives the core one result, so a short pause after that
   // leaves it idle for register writes.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      int         random_sent;
      int         run_len;
      int         period;
      int         window;
      logic [6:0] junk;
      logic       tick;

      random_sent = 0;
      do @(posedge clock); while (reset);

      // Directed part. First the reset settings, with hold cycles and junk in
      // the unused tick bits.
      settings++;
      push_tick(8'h00);
      push_tick(8'h01);
      push_tick(8'h01);
      push_tick(8'hFE);
      push_tick(8'hFF);
      push_tick(8'h01);
      drain();

      // Zero period (every tick wraps), full window, rotation on, zero step
      // and zero threshold, levels at both ends, junk above the width of every
      // narrow register and a write to the index past the list.
      write_reg(CSR_PWM_PERIOD, 24'hFFFE00);
      write_reg(CSR_ON_WINDOW, 24'hFFFFFF);
      write_reg(CSR_ROTATE_EN, 24'hFFFFFF);
      write_reg(CSR_COLOR_STEP, 24'hFFFF00);
      write_reg(CSR_ROT_THRESH, 24'hFFFF00);
      write_reg(CSR_LEFT_START, 24'hFFFFFF);
      write_reg(CSR_RIGHT_START, 24'h000000);
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      settings++;
      push_tick(8'h01);
      push_tick(8'h01);
      push_tick(8'h00);
      push_tick(8'h01);
      push_tick(8'h01);
      push_tick(8'h01);
      drain();

      // Largest period, empty window, largest step and threshold.
      write_reg(CSR_PWM_PERIOD, 24'h0001FF);
      write_reg(CSR_ON_WINDOW, 24'h000000);
      write_reg(CSR_COLOR_STEP, 24'h0000FF);
      write_reg(CSR_ROT_THRESH, 24'h0000FF);
      write_reg(CSR_LEFT_START, 24'hFF0000);
      write_reg(CSR_RIGHT_START, 24'h0000FF);
      settings++;
      push_tick(8'h01);
      push_tick(8'h01);
      push_tick(8'h00);
      push_tick(8'h01);
      drain();

      // A short period with the wheel turning: a wrap every third tick.
      write_reg(CSR_PWM_PERIOD, 24'h000002);
      write_reg(CSR_ON_WINDOW, 24'h000003);
      write_reg(CSR_COLOR_STEP, 24'h000080);
      write_reg(CSR_ROT_THRESH, 24'h000001);
      write_reg(CSR_LEFT_START, 24'h010000);
      write_reg(CSR_RIGHT_START, 24'h00FF00);
      settings++;
      repeat (8) push_tick(8'h01);
      drain();

      // Random part: runs of ticks, each under a fresh mix of register values.
      // Short periods dominate so that the phase wraps often and the wheel
      // goes through all of its segments; long periods show up now and then.
      while (random_sent < RANDOM_TICKS) begin
         quiet <= ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0:       period = 0;
            1:       period = 511;
            2:       period = $urandom_range(16, 511);
            default: period = $urandom_range(1, 15);
         endcase
         case ($urandom_range(0, 5))
            0:       window = 0;
            1:       window = 511;
            default: window = $urandom_range(0, (period + 2 > 511) ? 511 : period + 2);
         endcase
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_PWM_PERIOD, with_noise(CSR_DAT_W'(period), PHASE_W));
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_ON_WINDOW, with_noise(CSR_DAT_W'(window), PHASE_W));
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_ROTATE_EN,
                      with_noise(CSR_DAT_W'($urandom_range(0, 3) != 0), 1));
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_COLOR_STEP, with_noise(CSR_DAT_W'(pick_level()), LEVEL_W));
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_ROT_THRESH, with_noise(CSR_DAT_W'(pick_level()), LEVEL_W));
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_LEFT_START, {pick_level(), pick_level(), pick_level()});
         if ($urandom_range(0, 9) < 7)
            write_reg(CSR_RIGHT_START, {pick_level(), pick_level(), pick_level()});
         if ($urandom_range(0, 7) == 0) write_reg(CSR_UNUSED, CSR_DAT_W'($urandom()));
         settings++;

         run_len = $urandom_range(40, 140);
         if (run_len > RANDOM_TICKS - random_sent) run_len = RANDOM_TICKS - random_sent;
         repeat (run_len) begin
            tick = ($urandom_range(0, 6) != 0);
            junk = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'd0;
            push_tick({junk, tick});
            random_sent++;
         end
         drain();
      end

      $display("Sent %0d tick transfers (%0d random) over %0d register settings.",
               ticks_sent, random_sent, settings);
      $display("The phase wrapped %0d times, %0d of them turning the color wheel.",
               wrap_count, step_count);
      if (fail_count == 0) begin
         $display("[dual_rgb_pwm_color_wheel_core] OK");
      end else begin
         $display("[dual_rgb_pwm_color_wheel_core] ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #40_000_000;
      $display("Timed out with %0d results still expected.", pending);
      $display("[dual_rgb_pwm_color_wheel_core] ERROR");
      $finish;
   end

endmodule
